FILE: sv/hough_line_vote_accumulator_defines.svh
// Assertion macros used by the checker file of the Hough line vote accumulator.
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define HLVA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HLVA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/hlva_pkg.sv
// Shared types, constants and the angle table function of the Hough line vote accumulator.
package hlva_pkg;

    localparam int THETA_BINS_DEF = 256;
    localparam int RHO_BINS_DEF   = 256;
    localparam int COORD_BITS_DEF = 10;
    localparam int VOTE_BITS_DEF  = 16;

    localparam int IN_COORD_W = 10;
    localparam int SCALE_W    = 24;
    localparam int OUT_DATA_W = 56;
    localparam int BG_OUT_W   = 19;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd5793;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    localparam int AVG_FLOOR  = 6;
    localparam int BG_DEFAULT = 30;
    localparam logic [BG_OUT_W-1:0] BG_MAX = 19'h7FFFF;
    localparam logic [15:0] VOTES_OUT_MAX = 16'hFFFF;

    // Factorial steps of the Taylor series terms.
    localparam longint unsigned TAYLOR_COS_DIV [10] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned TAYLOR_SIN_DIV [10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PEAK   = 2'd3
    } t_hlva_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_VOTE,
        ST_DRAIN,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DIV_INIT,
        ST_DIV,
        ST_BG,
        ST_DONE
    } t_hlva_state;

    typedef struct packed {
        logic load_in;
        logic cnt_clr;
        logic cnt_inc;
        logic wr_zero;
        logic vote_issue;
        logic vote_add;
        logic scan_read;
        logic scan_clr;
        logic div_start;
        logic div_step;
        logic bg_load;
        logic out_load;
        logic out_peak;
    } t_hlva_cmd;

    typedef struct packed {
        logic sweep_last;
        logic theta_last;
        logic pipe_busy;
        logic div_done;
    } t_hlva_sts;

    // Q1.14 cosine or sine magnitude of an angle given in Q30, from a ten term series.
    function automatic int hlva_trig_q14(longint unsigned ang, bit want_sin);
        longint unsigned a2;
        longint unsigned term;
        longint          acc;
        longint unsigned q;
        a2   = (ang * ang) >> 30;
        term = want_sin ? ang : Q30_ONE;
        acc  = 0;
        for (int n = 0; n < 10; n++) begin
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
            if (want_sin) begin
                term = ((term * a2) >> 30) / TAYLOR_SIN_DIV[n];
            end else begin
                term = ((term * a2) >> 30) / TAYLOR_COS_DIV[n];
            end
        end
        if (acc < 0) begin
            return 0;
        end
        q = (longint'(acc) + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return int'(q);
    endfunction

endpackage

FILE: sv/hlva_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module hlva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/hlva_ctrl.sv
// Sequencer of the Hough line vote accumulator: runs sweeps, votes, the scan and the result handoff.
module hlva_ctrl
    import hlva_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_hlva_op  i_op,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_hlva_cmd o_cmd,
    input  t_hlva_sts i_sts
);
    t_hlva_state r_state, n_state;
    t_hlva_op    r_op, n_op;
    logic        r_out_valid, n_out_valid;
    logic        accept;
    logic        out_free;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_op        <= OP_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            ST_INIT: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_op = i_op;
                    unique case (i_op)
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_ADD:    n_state = ST_VOTE;
                        OP_REMOVE: n_state = ST_VOTE;
                        OP_PEAK:   n_state = ST_SCAN;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_VOTE: begin
                if (i_sts.theta_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL: n_state = ST_DIV_INIT;
            ST_DIV_INIT:  n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_BG;
                end
            end
            ST_BG: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_in    = accept;
        o_cmd.vote_add   = (r_op == OP_ADD);
        o_cmd.out_peak   = (r_op == OP_PEAK);
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                o_cmd.wr_zero = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.cnt_clr  = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            ST_VOTE:     o_cmd.vote_issue = 1'b1;
            ST_SCAN: begin
                o_cmd.scan_read = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
            end
            ST_DIV_INIT: o_cmd.div_start = 1'b1;
            ST_DIV:      o_cmd.div_step  = !i_sts.div_done;
            ST_BG:       o_cmd.bg_load   = 1'b1;
            ST_DONE:     o_cmd.out_load  = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

FILE: sv/hlva_dp.sv
// Datapath: vote table, rho pipeline, peak scan, mean divider and result register.
module hlva_dp
    import hlva_pkg::*;
#(
    parameter int THETA_BINS = THETA_BINS_DEF,
    parameter int RHO_BINS   = RHO_BINS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int VOTE_BITS  = VOTE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_hlva_cmd             i_cmd,
    output t_hlva_sts             o_sts,
    input  logic [IN_COORD_W-1:0] i_x,
    input  logic [IN_COORD_W-1:0] i_y,
    input  logic                  i_cfg_valid,
    input  logic [SCALE_W-1:0]    i_cfg_data,
    output logic [OUT_DATA_W-1:0] o_result
);
    localparam int DEPTH  = THETA_BINS * RHO_BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = $clog2(THETA_BINS);
    localparam int RW     = $clog2(RHO_BINS);
    localparam int PROD_W = COORD_BITS + 17;
    localparam int R_W    = PROD_W + 1;
    localparam int P_W    = R_W + SCALE_W + 1;
    localparam int Q_W    = P_W - 30;
    localparam int SUM_W  = AW + VOTE_BITS;
    localparam int CNT_W  = AW + 1;
    localparam int DC_W   = $clog2(SUM_W + 1);
    localparam int BG_W   = SUM_W + 3;
    localparam logic [VOTE_BITS-1:0] VOTE_MAX = '1;

    // Angle tables, worked out at elaboration.
    logic signed [15:0] cos_tab [THETA_BINS];
    logic signed [15:0] sin_tab [THETA_BINS];

    for (genvar g = 0; g < THETA_BINS; g++) begin : g_trig
        localparam longint MAG_N = (2 * g >= THETA_BINS) ? (2 * g - THETA_BINS)
                                                          : (THETA_BINS - 2 * g);
        localparam longint unsigned ANG = (longint'(MAG_N) * PI_Q30) / (2 * THETA_BINS);
        localparam int COS_V = hlva_trig_q14(ANG, 1'b0);
        localparam int SIN_V = hlva_trig_q14(ANG, 1'b1);
        assign cos_tab[g] = 16'(COS_V);
        assign sin_tab[g] = (2 * g < THETA_BINS) ? 16'(-SIN_V) : 16'(SIN_V);
    end

    logic [SCALE_W-1:0]    r_scale;
    logic [COORD_BITS-1:0] r_x, r_y;

    logic [AW-1:0] r_addr;
    logic [TW-1:0] r_t;
    logic [RW-1:0] r_r;
    logic [AW-1:0] r_row;

    logic                     r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic signed [PROD_W-1:0] r_s1_xc, r_s1_ys;
    logic signed [R_W-1:0]    r_s2_r;
    logic signed [P_W-1:0]    r_s3_p;
    logic [AW-1:0]            r_s1_row, r_s2_row, r_s3_row, r_s4_addr;
    logic signed [P_W-1:0]    p_off;
    logic [Q_W-1:0]           q;
    logic [RW-1:0]            bin;
    logic [AW-1:0]            vote_addr;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VOTE_BITS-1:0] ram_wdata, ram_rdata, upd;

    logic                 r_sc_v;
    logic [TW-1:0]        r_sc_t, r_tmax;
    logic [RW-1:0]        r_sc_r, r_rmax;
    logic [VOTE_BITS-1:0] r_hmax;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_count;

    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [DC_W-1:0]  r_dcnt;
    logic [CNT_W:0]   rem_sh;
    logic             ge;
    logic [SUM_W-1:0] avg;
    logic [BG_W-1:0]  bg_full, r_bg;

    logic [7:0]            res_theta, res_rho;
    logic [15:0]           res_votes;
    logic [BG_OUT_W-1:0]   res_bg;
    logic                  res_found;
    logic [OUT_DATA_W-1:0] r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= COORD_BITS'(i_x);
            r_y <= COORD_BITS'(i_y);
        end
    end

    // Sweep counters walk the table theta-major; voting steps one theta row at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_addr <= '0;
            r_t    <= '0;
            r_r    <= '0;
            r_row  <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_addr <= r_addr + AW'(1);
            if (r_r == RW'(RHO_BINS - 1)) begin
                r_r <= '0;
                r_t <= r_t + TW'(1);
            end else begin
                r_r <= r_r + RW'(1);
            end
        end else if (i_cmd.vote_issue) begin
            r_t   <= r_t + TW'(1);
            r_row <= r_row + AW'(RHO_BINS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_sc_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.vote_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_sc_v <= i_cmd.scan_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_xc   <= PROD_W'($signed({1'b0, r_x})) * PROD_W'(cos_tab[r_t]);
        r_s1_ys   <= PROD_W'($signed({1'b0, r_y})) * PROD_W'(sin_tab[r_t]);
        r_s1_row  <= r_row;
        r_s2_r    <= R_W'(r_s1_xc) + R_W'(r_s1_ys);
        r_s2_row  <= r_s1_row;
        r_s3_p    <= P_W'(r_s2_r) * P_W'($signed({1'b0, r_scale}));
        r_s3_row  <= r_s2_row;
        r_s4_addr <= vote_addr;
        r_sc_t    <= r_t;
        r_sc_r    <= r_r;
    end

    // Rho in Q30 plus half the rho range, floored and clamped to a bin.
    assign p_off = r_s3_p + (P_W'(RHO_BINS) <<< 29);
    assign q     = p_off[P_W-1:30];

    always_comb begin
        if (p_off[P_W-1]) begin
            bin = '0;
        end else if (q >= Q_W'(RHO_BINS)) begin
            bin = RW'(RHO_BINS - 1);
        end else begin
            bin = RW'(q);
        end
    end

    assign vote_addr = r_s3_row + AW'(bin);

    always_comb begin
        if (i_cmd.vote_add) begin
            upd = (ram_rdata == VOTE_MAX) ? ram_rdata : ram_rdata + VOTE_BITS'(1);
        end else begin
            upd = (ram_rdata == '0) ? ram_rdata : ram_rdata - VOTE_BITS'(1);
        end
    end

    // Each theta row is touched once per point, so the read-modify-write never collides.
    assign ram_we    = i_cmd.wr_zero || r_s4_v;
    assign ram_waddr = i_cmd.wr_zero ? r_addr : r_s4_addr;
    assign ram_wdata = i_cmd.wr_zero ? '0 : upd;
    assign ram_raddr = r_s3_v ? vote_addr : r_addr;

    hlva_ram #(
        .WIDTH (VOTE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Peak scan: first maximum wins because only a strictly larger count replaces it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_hmax  <= '0;
            r_tmax  <= '0;
            r_rmax  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (r_sc_v) begin
            if (ram_rdata != '0) begin
                r_sum   <= r_sum + SUM_W'(ram_rdata);
                r_count <= r_count + CNT_W'(1);
            end
            if (ram_rdata > r_hmax) begin
                r_hmax <= ram_rdata;
                r_tmax <= r_sc_t;
                r_rmax <= r_sc_r;
            end
        end
    end

    // Restoring divider for the mean, one quotient bit per cycle.
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? CNT_W'(rem_sh - {1'b0, r_count}) : CNT_W'(rem_sh);
            r_quo  <= {r_quo[SUM_W-2:0], ge};
            r_dcnt <= r_dcnt + DC_W'(1);
        end
    end

    // Five times the mean is a shift and an add; a mean at or below AVG_FLOOR gives BG_DEFAULT.
    assign avg     = (r_count == '0) ? '0 : r_quo;
    assign bg_full = (avg > SUM_W'(AVG_FLOOR)) ? (BG_W'({avg, 2'b00}) + BG_W'(avg))
                                                : BG_W'(BG_DEFAULT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.bg_load) begin
            r_bg <= bg_full;
        end
    end

    assign res_theta = 8'(r_tmax);
    assign res_rho   = 8'(r_rmax);
    assign res_votes = (32'(r_hmax) > 32'(VOTES_OUT_MAX)) ? VOTES_OUT_MAX : 16'(r_hmax);
    assign res_bg    = (r_bg > BG_W'(BG_MAX)) ? BG_MAX : BG_OUT_W'(r_bg);
    assign res_found = (BG_W'(r_hmax) > r_bg);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_peak) begin
                r_result <= OUT_DATA_W'({res_found, res_bg, res_votes, res_rho, res_theta});
            end else begin
                r_result <= '0;
            end
        end
    end

    assign o_result         = r_result;
    assign o_sts.sweep_last = (r_addr == AW'(DEPTH - 1));
    assign o_sts.theta_last = (r_t == TW'(THETA_BINS - 1));
    assign o_sts.pipe_busy  = r_s1_v || r_s2_v || r_s3_v || r_s4_v;
    assign o_sts.div_done   = (r_dcnt == DC_W'(SUM_W));
endmodule

FILE: sv/hough_line_vote_accumulator.sv
// Clear: one table entry written per cycle.
// Add or remove point: one read-modify-write per theta bin on the table RAM.
// Find peak: a table scan, then a bit-serial mean divider. One item is in work at a time; a finished
// word waits in the output register.
// Reset is synchronous, active low; afterwards a clearing pass zeroes the table before the first word
// is accepted. Configuration writes are always taken.
module hough_line_vote_accumulator
    import hlva_pkg::*;
#(
    parameter int THETA_BINS = THETA_BINS_DEF,
    parameter int RHO_BINS   = RHO_BINS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int VOTE_BITS  = VOTE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // opcode[1:0], pixel_x[11:2], pixel_y[21:12], zero pad [23:22]
    input  logic [23:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // peak_theta_bin[7:0], peak_rho_bin[15:8], peak_votes[31:16],
    // background_level[50:32], line_found[51], zero pad [55:52]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SCALE_W-1:0]    i_cfg_data
);
    t_hlva_cmd cmd;
    t_hlva_sts sts;
    t_hlva_op  op;

    assign op          = t_hlva_op'(s_axis_tdata[1:0]);
    assign o_cfg_ready = 1'b1;

    hlva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (op),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    hlva_dp #(
        .THETA_BINS (THETA_BINS),
        .RHO_BINS   (RHO_BINS),
        .COORD_BITS (COORD_BITS),
        .VOTE_BITS  (VOTE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_x         (s_axis_tdata[11:2]),
        .i_y         (s_axis_tdata[21:12]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_result    (m_axis_tdata)
    );
endmodule

FILE: sv/hlva_checker.sv
// Port-level checker of the Hough line vote accumulator and its bind.
`include "hough_line_vote_accumulator_defines.svh"

module hlva_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    // A stalled result word holds its value.
    `HLVA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    // Only one item is in work: input closes right after an accepted word.
    `HLVA_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input still open after accept")
    // A found line reports a nonzero vote count.
    `HLVA_ASSERT(a_found_votes, m_axis_tvalid && m_axis_tdata[51] |-> m_axis_tdata[31:16] != 16'd0, "line found with no votes")
    // A reset cycle leaves no result valid and the input closed.
    `HLVA_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !m_axis_tvalid && !s_axis_tready, "block active right after reset")
endmodule

bind hough_line_vote_accumulator hlva_checker u_hlva_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench of the Hough line vote accumulator with its own vote table model.
module tb_top;
    import hlva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = THETA_BINS_DEF;
    localparam int NR = RHO_BINS_DEF;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        logic        found;
        logic [18:0] bg;
        logic [15:0] votes;
        logic [7:0]  rho;
        logic [7:0]  theta;
    } t_peak_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [SCALE_W-1:0] i_cfg_data = '0;

    hough_line_vote_accumulator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state: vote counters, angle tables and the rho scale register.
    logic [15:0] vote_tbl [NT*NR];
    int          cos_tbl [NT];
    int          sin_tbl [NT];
    logic [SCALE_W-1:0] rho_scale_m;
    t_peak_word  pending_results [$];
    int          errors = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;
    int          px_list [$];
    int          py_list [$];

    function automatic int to_q14(longint v);
        longint unsigned q;
        if (v < 0) return 0;
        q = (longint'(v) + 64'd32768) >> 16;
        return (q > 16384) ? 16384 : int'(q);
    endfunction

    task automatic build_angles();
        longint num;
        longint unsigned a, a2, tc, ts, k;
        longint cs, ss;
        int s;
        for (int t = 0; t < NT; t++) begin
            num = 2 * t - NT;
            a = ((num < 0 ? -num : num) * 64'd3373259426) / (2 * NT);
            a2 = (a * a) >> 30;
            tc = 64'd1 << 30;
            ts = a;
            cs = 0;
            ss = 0;
            for (int n = 0; n < 10; n++) begin
                k = 2 * n;
                if (n % 2) begin
                    cs -= longint'(tc);
                    ss -= longint'(ts);
                end else begin
                    cs += longint'(tc);
                    ss += longint'(ts);
                end
                tc = ((tc * a2) >> 30) / ((k + 1) * (k + 2));
                ts = ((ts * a2) >> 30) / ((k + 2) * (k + 3));
            end
            cos_tbl[t] = to_q14(cs);
            s = to_q14(ss);
            sin_tbl[t] = (num < 0) ? -s : s;
        end
    endtask

    function automatic int rho_of(int x, int y, int t);
        longint p;
        p = (longint'(x) * cos_tbl[t] + longint'(y) * sin_tbl[t]) * longint'(rho_scale_m)
            + (longint'(NR) << 29);
        if (p < 0) return 0;
        p = p >>> 30;
        return (p >= NR) ? NR - 1 : int'(p);
    endfunction

    task automatic predict_word(t_hlva_op op, int x, int y);
        t_peak_word w;
        longint unsigned sum, cnt, avg, bg;
        int idx, hmax, tm, rm;
        w = '0;
        case (op)
            OP_CLEAR: begin
                foreach (vote_tbl[i]) vote_tbl[i] = '0;
            end
            OP_ADD, OP_REMOVE: begin
                for (int t = 0; t < NT; t++) begin
                    idx = t * NR + rho_of(x, y, t);
                    if (op == OP_ADD && vote_tbl[idx] != 16'hFFFF) vote_tbl[idx]++;
                    if (op == OP_REMOVE && vote_tbl[idx] != 0) vote_tbl[idx]--;
                end
            end
            default: begin
                sum = 0; cnt = 0; hmax = 0; tm = 0; rm = 0;
                for (int i = 0; i < NT * NR; i++) begin
                    if (vote_tbl[i] != 0) begin
                        sum += 64'(vote_tbl[i]);
                        cnt++;
                    end
                    if (vote_tbl[i] > hmax) begin
                        hmax = int'(vote_tbl[i]);
                        tm = i / NR;
                        rm = i % NR;
                    end
                end
                avg = cnt ? sum / cnt : 0;
                bg = (avg > AVG_FLOOR) ? 5 * avg : BG_DEFAULT;
                w.theta = tm[7:0];
                w.rho = rm[7:0];
                w.votes = hmax[15:0];
                w.bg = (bg > 524287) ? BG_MAX : bg[18:0];
                w.found = hmax > bg;
            end
        endcase
        pending_results.push_back(w);
    endtask

    // Offers one word; the previous valid stays high unless a gap is taken.
    task automatic send_word(t_hlva_op op, int x, int y);
        if (!calm && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, y[9:0], x[9:0], op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_word(op, x, y);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rho_scale_m = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        t_peak_word got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[51:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.theta !== want.theta) begin
                    $error("peak_theta_bin exp %0d got %0d", want.theta, got.theta);
                    errors++;
                end
                if (got.rho !== want.rho) begin
                    $error("peak_rho_bin exp %0d got %0d", want.rho, got.rho);
                    errors++;
                end
                if (got.votes !== want.votes) begin
                    $error("peak_votes exp %0d got %0d", want.votes, got.votes);
                    errors++;
                end
                if (got.bg !== want.bg) begin
                    $error("background_level exp %0d got %0d", want.bg, got.bg);
                    errors++;
                end
                if (got.found !== want.found) begin
                    $error("line_found exp %0d got %0d", want.found, got.found);
                    errors++;
                end
            end
        end
    end

    // Watchdog over cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic add_line(int n, bit keep);
        int kind, c, x, y;
        kind = $urandom_range(2);
        c = $urandom_range(1023);
        for (int i = 0; i < n; i++) begin
            x = $urandom_range(1023);
            y = (kind == 0) ? c : (kind == 1) ? x : (c ^ x);
            if (kind == 2) begin
                y = c;
                x = (i * 7 + c) & 10'h3FF;
                y = x;
            end
            send_word(OP_ADD, x, y);
            if (keep) begin
                px_list.push_back(x);
                py_list.push_back(y);
            end
        end
    endtask

    task automatic test_empty_and_extremes();
        send_word(OP_PEAK, 0, 0);
        send_word(OP_REMOVE, 1023, 1023);
        send_word(OP_ADD, 0, 0);
        send_word(OP_ADD, 1023, 0);
        send_word(OP_ADD, 0, 1023);
        send_word(OP_ADD, 1023, 1023);
        send_word(OP_ADD, 1023, 1023);
        send_word(OP_REMOVE, 0, 0);
        send_word(OP_REMOVE, 0, 0);
        send_word(OP_PEAK, 0, 0);
        send_word(OP_CLEAR, 1023, 1023);
        send_word(OP_PEAK, 0, 0);
    endtask

    task automatic test_line_found();
        for (int i = 0; i < 40; i++) send_word(OP_ADD, i * 20, 500);
        send_word(OP_PEAK, 0, 0);
    endtask

    task automatic test_scale_extremes();
        write_scale('0);
        send_word(OP_ADD, 700, 300);
        send_word(OP_PEAK, 0, 0);
        write_scale(24'hFFFFFF);
        send_word(OP_ADD, 1023, 5);
        send_word(OP_ADD, 3, 1000);
        send_word(OP_PEAK, 0, 0);
        write_scale(24'd11586);
        send_word(OP_CLEAR, 0, 0);
        write_scale(SCALE_RESET);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) send_word(OP_ADD, $urandom_range(1023), $urandom_range(1023));
        wait_drained();
    endtask

    task automatic test_random();
        int done, k;
        done = 0;
        while (done < 2000) begin
            calm = (done >= 600 && done < 900);
            if (done % 250 < 40 && done > 0 && $urandom_range(3) == 0) begin
                send_word(OP_PEAK, 0, 0);
                done += 40;
            end else if ($urandom_range(99) < 60) begin
                k = $urandom_range(15, 45);
                add_line(k, 1'b1);
                done += k;
            end else if ($urandom_range(99) < 60 && px_list.size() > 0) begin
                for (int i = 0; i < 10 && px_list.size() > 0; i++) begin
                    k = $urandom_range(px_list.size() - 1);
                    send_word(OP_REMOVE, px_list[k], py_list[k]);
                    px_list.delete(k);
                    py_list.delete(k);
                    done++;
                end
            end else begin
                send_word(t_hlva_op'($urandom_range(1, 2)), $urandom_range(1023),
                          $urandom_range(1023));
                done++;
            end
            if (done >= 1000 && done < 1040) begin
                send_word(OP_PEAK, 0, 0);
                write_scale(SCALE_W'($urandom_range(2000, 12000)));
                send_word(OP_CLEAR, 0, 0);
                px_list.delete();
                py_list.delete();
                done = 1040;
            end
        end
        calm = 1'b0;
        send_word(OP_PEAK, 0, 0);
    endtask

    initial begin
        build_angles();
        foreach (vote_tbl[i]) vote_tbl[i] = '0;
        rho_scale_m = SCALE_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_extremes();
        test_line_found();
        test_scale_extremes();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/hlva_pkg.sv
sv/hlva_ram.sv
sv/hlva_ctrl.sv
sv/hlva_dp.sv
sv/hough_line_vote_accumulator.sv
sv/hlva_checker.sv
tb/tb_top.sv
